// File: hdl/xmsx_pkg.sv
`default_nettype none

package xmsx_pkg;

  localparam logic [63:0] MIX_MULT    = 64'hcdb32970830fcaa1;
  localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
  localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];
  localparam int unsigned FOLD_SHIFT  = 32;
  localparam int unsigned FINAL_SHIFT = 47;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic CFG_SEED = 1'b0;
  localparam logic CFG_SWAP = 1'b1;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_M0,
    STEP_M1,
    STEP_M2,
    STEP_FOLD
  } step_t;

  typedef struct packed {
    logic  ld_begin;
    logic  ld_data;
    logic  ld_final;
    logic  ld_out;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic left_zero;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/xmsx_in_if.sv
`default_nettype none

interface xmsx_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] msg_len;
  logic [31:0] data_word;

  modport source (output valid, output func, output msg_len, output data_word, input ready);
  modport sink (input valid, input func, input msg_len, input data_word, output ready);
endinterface

`default_nettype wire

// File: hdl/xmsx_out_if.sv
`default_nettype none

interface xmsx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// File: hdl/xmsx_dp.sv
`default_nettype none

module xmsx_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  input  wire logic [31:0]      in_msg_len,
  input  wire logic [31:0]      in_data_word,
  input  wire xmsx_pkg::cmd_t   cmd,
  output xmsx_pkg::status_t     sts,
  output logic [31:0]           hash_value
);

  logic [31:0] seed_r;
  logic        swap_r;
  logic [63:0] h_r;
  logic [63:0] h_nxt;
  logic [31:0] left_r;
  logic [31:0] left_nxt;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [63:0] prod_r;
  logic [31:0] hash_r;
  logic [31:0] hash_nxt;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] word_sw;
  logic [31:0] word_m;
  logic        left_lt4;
  logic [63:0] sum;

  assign word_sw  = swap_r ? {in_data_word[7:0], in_data_word[15:8],
                              in_data_word[23:16], in_data_word[31:24]}
                           : in_data_word;
  assign left_lt4 = (left_r[31:2] == 30'd0);
  assign sum      = acc_r + {prod_r[31:0], 32'd0};
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    word_m = word_sw;
    if (left_lt4) begin
      case (left_r[1:0])
        2'd1:    word_m = word_sw & 32'h0000_00FF;
        2'd2:    word_m = word_sw & 32'h0000_FFFF;
        2'd3:    word_m = word_sw & 32'h00FF_FFFF;
        default: word_m = word_sw;
      endcase
    end
  end

  always_comb begin
    mul_a = h_r[31:0];
    mul_b = xmsx_pkg::MIX_MULT_LO;
    case (cmd.step)
      xmsx_pkg::STEP_M1: mul_b = xmsx_pkg::MIX_MULT_HI;
      xmsx_pkg::STEP_M2: mul_a = h_r[63:32];
      default: begin
        mul_a = h_r[31:0];
        mul_b = xmsx_pkg::MIX_MULT_LO;
      end
    endcase
  end

  always_comb begin
    h_nxt    = h_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    hash_nxt = hash_r;
    if (cmd.ld_begin) begin
      h_nxt    = {seed_r, seed_r} ^ {32'd0, in_msg_len};
      left_nxt = in_msg_len;
    end
    if (cmd.ld_data) begin
      h_nxt    = h_r ^ {32'd0, word_m};
      left_nxt = left_lt4 ? 32'd0 : left_r - 32'd4;
    end
    if (cmd.ld_final) begin
      h_nxt = h_r ^ 64'(h_r >> xmsx_pkg::FINAL_SHIFT);
    end
    if (cmd.ld_out) begin
      hash_nxt = h_r[31:0];
    end
    case (cmd.step)
      xmsx_pkg::STEP_M1:   acc_nxt = prod_r;
      xmsx_pkg::STEP_M2:   acc_nxt = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
      xmsx_pkg::STEP_FOLD: h_nxt = sum ^ 64'(sum >> xmsx_pkg::FOLD_SHIFT);
      default:             acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
      swap_r <= 1'b0;
      left_r <= 32'd0;
    end else begin
      left_r <= left_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          xmsx_pkg::CFG_SEED: seed_r <= cfg_wdata;
          xmsx_pkg::CFG_SWAP: swap_r <= cfg_wdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    acc_r  <= acc_nxt;
    hash_r <= hash_nxt;
    if (cmd.step != xmsx_pkg::STEP_NONE) begin
      prod_r <= mul_p;
    end
  end

  assign sts.left_zero = (left_r == 32'd0);
  assign hash_value    = hash_r;

endmodule

`default_nettype wire

// File: hdl/xmsx_ctrl.sv
`default_nettype none

module xmsx_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire xmsx_pkg::status_t sts,
  output xmsx_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_FOLD,
    ST_LDFIN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   msg_open_r;
  logic   msg_open_nxt;
  logic   final_r;
  logic   final_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    msg_open_nxt  = msg_open_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = xmsx_pkg::STEP_NONE;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == xmsx_pkg::FUNC_BEGIN) begin
            cmd.ld_begin = 1'b1;
            msg_open_nxt = 1'b1;
            final_nxt    = 1'b0;
            state_nxt    = ST_M0;
          end else if (msg_open_r) begin
            cmd.ld_data = 1'b1;
            final_nxt   = 1'b0;
            state_nxt   = ST_M0;
          end
        end
      end
      ST_M0: begin
        cmd.step  = xmsx_pkg::STEP_M0;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        cmd.step  = xmsx_pkg::STEP_M1;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        cmd.step  = xmsx_pkg::STEP_M2;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.step = xmsx_pkg::STEP_FOLD;
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (sts.left_zero) begin
          state_nxt = ST_LDFIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LDFIN: begin
        cmd.ld_final = 1'b1;
        final_nxt    = 1'b1;
        state_nxt    = ST_M0;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          msg_open_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      msg_open_r  <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      msg_open_r  <= msg_open_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hdl/xor_multiply_shift_hash32_top.sv
// Streaming 32-bit multiply-xorshift message hash.
// An item on in_stream with func 0 opens a message and carries its byte length;
// items with func 1 carry a 32-bit word each, first byte in 7:0 (swap: 31:24).
// Data items that arrive with no message open are taken and dropped.
// When the last byte has been mixed, the 32-bit hash appears on out_stream.
// The configuration port writes the seed (index 0) and the byte swap enable
// (index 1); the user must write only while the block is idle (not enforced).
// Every round runs on one shared 32x32 multiplier in steps M0, M1 and M2 plus
// a fold step, and an item is taken only once the round before it has finished.
// The last word of a message, or a begin item of length zero, adds the final
// round: LDFIN applies the final xorshift, another round runs, and EMIT loads
// the result into the output register; the next item is taken after that.
// The result sits in an output register, so the next message is accepted
// while it waits; only a second result blocks until the first is taken.
// A synchronous reset (rst_n low) clears the configuration, closes any open
// message and drops an undelivered result.
`default_nettype none

module xor_multiply_shift_hash32_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  xmsx_in_if.sink          in_stream,
  xmsx_out_if.source       out_stream
);

  xmsx_pkg::cmd_t    cmd;
  xmsx_pkg::status_t sts;

  xmsx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_func   (in_stream.func),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xmsx_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_msg_len   (in_stream.msg_len),
    .in_data_word (in_stream.data_word),
    .cmd          (cmd),
    .sts          (sts),
    .hash_value   (out_stream.hash_value)
  );

endmodule

`default_nettype wire

// File: tb/sv/xor_multiply_shift_hash32_top_tb.sv
`timescale 1ns / 100ps

module xor_multiply_shift_hash32_top_tb;

  typedef struct packed {
    logic        func;
    logic [31:0] msg_len;
    logic [31:0] data_word;
  } hash_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  xmsx_in_if  in_bus ();
  xmsx_out_if out_bus ();

  xor_multiply_shift_hash32_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_bus),
    .out_stream (out_bus)
  );

  hash_item_t  pending_items[$];
  logic [31:0] expected_hashes[$];
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned error_count;
  logic        in_took;
  logic        quiet;
  logic        sink_hold;
  int unsigned src_gap;
  int unsigned sink_gap;
  hash_item_t  drive_item;
  hash_item_t  seen_item;
  logic [31:0] want_hash;

  logic [31:0] seed_copy;
  logic        swap_copy;
  logic [63:0] hash_acc;
  logic [31:0] bytes_due;
  logic        msg_active;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] hash_round(logic [63:0] h, logic [31:0] d);
    logic [63:0] p;
    p = (h ^ {32'd0, d}) * xmsx_pkg::MIX_MULT;
    return p ^ (p >> xmsx_pkg::FOLD_SHIFT);
  endfunction

  task automatic emit_hash();
    hash_acc = hash_round(hash_acc, 32'(hash_acc >> xmsx_pkg::FINAL_SHIFT));
    msg_active = 1'b0;
    expected_hashes.push_back(hash_acc[31:0]);
  endtask

  task automatic hash_step(hash_item_t it);
    logic [31:0] word;
    if (it.func == xmsx_pkg::FUNC_BEGIN) begin
      hash_acc = hash_round({seed_copy, seed_copy}, it.msg_len);
      bytes_due = it.msg_len;
      msg_active = 1'b1;
      if (bytes_due == 32'd0) emit_hash();
    end else if (msg_active) begin
      word = swap_copy ? {it.data_word[7:0], it.data_word[15:8], it.data_word[23:16],
                          it.data_word[31:24]} : it.data_word;
      if (bytes_due < 32'd4) begin
        word = word & ((32'd1 << (bytes_due * 8)) - 32'd1);
        bytes_due = 32'd0;
      end else begin
        bytes_due = bytes_due - 32'd4;
      end
      hash_acc = hash_round(hash_acc, word);
      if (bytes_due == 32'd0) emit_hash();
    end
  endtask

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        seen_item = {in_bus.func, in_bus.msg_len, in_bus.data_word};
        hash_step(seen_item);
        items_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_hashes.size() == 0) begin
          report_error($sformatf("hash_value %08h with no item pending", out_bus.hash_value));
        end else begin
          want_hash = expected_hashes.pop_front();
          if (out_bus.hash_value !== want_hash) begin
            report_error($sformatf("hash_value %08h, expected %08h", out_bus.hash_value,
                                   want_hash));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_bus.valid || in_took)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(1, 16) - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.func <= drive_item.func;
        in_bus.msg_len <= drive_item.msg_len;
        in_bus.data_word <= drive_item.data_word;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_hold) begin
      out_bus.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(1, 16) - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_begin(logic [31:0] len);
    pending_items.push_back({xmsx_pkg::FUNC_BEGIN, len, 32'($urandom())});
    items_queued++;
  endtask

  task automatic push_data(logic [31:0] word);
    pending_items.push_back({xmsx_pkg::FUNC_DATA, 32'($urandom()), word});
    items_queued++;
  endtask

  task automatic push_message(int unsigned len);
    push_begin(len);
    for (int unsigned i = 0; i < (len + 3) / 4; i++) push_data(rand_word());
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == xmsx_pkg::CFG_SEED) seed_copy = value;
    else swap_copy = value[0];
  endtask

  task automatic settle();
    while (items_taken != items_queued || expected_hashes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned made;
    int unsigned len;
    int unsigned words;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_data(rand_word());
      end else if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        push_message(len);
        made += 1 + (len + 3) / 4;
        if ($urandom_range(0, 9) == 0) push_data(rand_word());
      end else begin
        len = $urandom_range(0, 1) ? $urandom() : $urandom_range(5, 40);
        words = $urandom_range(0, 3);
        push_begin(len);
        for (int unsigned i = 0; i < words; i++) push_data(rand_word());
        made += 1 + words;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = xmsx_pkg::CFG_SEED;
    cfg_wdata = 32'd0;
    in_bus.valid = 1'b0;
    in_bus.func = xmsx_pkg::FUNC_BEGIN;
    in_bus.msg_len = 32'd0;
    in_bus.data_word = 32'd0;
    out_bus.ready = 1'b0;
    quiet = 1'b0;
    sink_hold = 1'b0;
    src_gap = 0;
    sink_gap = 0;
    items_queued = 0;
    items_taken = 0;
    error_count = 0;
    in_took = 1'b0;
    seed_copy = 32'd0;
    swap_copy = 1'b0;
    hash_acc = 64'd0;
    bytes_due = 32'd0;
    msg_active = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Stray data with no message open, a zero-length message, and every tail size.
    push_data(32'hffff_ffff);
    push_begin(32'd0);
    push_begin(32'd1);
    push_data(32'hffff_ffff);
    push_begin(32'd2);
    push_data(32'h1234_5678);
    push_begin(32'd3);
    push_data(32'hffff_ffff);
    push_begin(32'd4);
    push_data(32'h0000_0000);
    push_begin(32'd5);
    push_data(32'hffff_ffff);
    push_data(32'hffff_ffff);
    // A maximal length is abandoned by a new begin item.
    push_begin(32'hffff_ffff);
    push_data(32'ha5a5_a5a5);
    push_begin(32'd8);
    push_data(32'h5a5a_5a5a);
    push_data(32'h8000_0001);
    push_data(32'h0bad_f00d);
    settle();

    write_reg(xmsx_pkg::CFG_SEED, 32'hffff_ffff);
    write_reg(xmsx_pkg::CFG_SWAP, 32'd1);
    push_begin(32'd3);
    push_data(32'h1122_3344);
    push_begin(32'd6);
    push_data(32'hdead_beef);
    push_data(32'h0102_0304);
    random_traffic(150);
    settle();

    // The receiver stalls for a long stretch so the block backs up.
    write_reg(xmsx_pkg::CFG_SEED, $urandom());
    write_reg(xmsx_pkg::CFG_SWAP, 32'd0);
    fork
      begin
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) push_message($urandom_range(0, 8));
    random_traffic(150);
    settle();

    write_reg(xmsx_pkg::CFG_SEED, 32'd0);
    write_reg(xmsx_pkg::CFG_SWAP, 32'd1);
    random_traffic(220);
    settle();

    write_reg(xmsx_pkg::CFG_SEED, $urandom());
    write_reg(xmsx_pkg::CFG_SWAP, $urandom_range(0, 1));
    random_traffic(220);
    settle();

    write_reg(xmsx_pkg::CFG_SEED, 32'h8000_0001);
    write_reg(xmsx_pkg::CFG_SWAP, 32'd0);
    quiet = 1'b1;
    random_traffic(220);
    settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
hdl/xmsx_pkg.sv
hdl/xmsx_in_if.sv
hdl/xmsx_out_if.sv
hdl/xmsx_dp.sv
hdl/xmsx_ctrl.sv
hdl/xor_multiply_shift_hash32_top.sv
tb/sv/xor_multiply_shift_hash32_top_tb.sv
